[src/scfg_pkg.sv]
// ----------------------------------------------------------------------------
// scfg_pkg
// Shared constants and types of the Super IO configuration port: unlock key,
// register indexes, the serial logical device table and the request struct.
// ----------------------------------------------------------------------------
`default_nettype none

package scfg_pkg;

  localparam int NUM_SERIAL_DEVICES = 6;
  localparam int SLOT_W = (NUM_SERIAL_DEVICES > 1) ? $clog2(NUM_SERIAL_DEVICES) : 1;

  // Unlock key bytes, in order.
  localparam int KEY_LEN = 4;
  localparam logic [7:0] UNLOCK_KEY [KEY_LEN] = '{8'h87, 8'h01, 8'h55, 8'h55};

  // Register indexes.
  localparam logic [7:0] REG_LOCK      = 8'h02;
  localparam logic [7:0] REG_LDN       = 8'h07;
  localparam logic [7:0] REG_ID_HIGH   = 8'h20;
  localparam logic [7:0] REG_ID_LOW    = 8'h21;
  localparam logic [7:0] REG_ENABLE    = 8'h30;
  localparam logic [7:0] REG_BASE_HIGH = 8'h60;
  localparam logic [7:0] REG_BASE_LOW  = 8'h61;
  localparam logic [7:0] REG_CLOCK     = 8'hF0;

  // Bit of a lock-register write that returns the port to the locked state.
  localparam int LOCK_BIT = 1;

  // Logical device numbers of the serial devices, one per slot.
  localparam logic [7:0] SERIAL_LDN [6] = '{8'h01, 8'h02, 8'h08, 8'h09, 8'h0B, 8'h0C};

  // Configuration register addresses (byte address bit 2 selects the register).
  localparam logic CFG_IDX_CHIP_IDENTITY = 1'b0;
  localparam logic [15:0] CHIP_IDENTITY_RESET = 16'h8786;

  localparam logic [7:0] LOCKED_READ = 8'hFF;

  // Request from the access decoder to the logical device register file.
  typedef struct packed {
    logic       wr;
    logic [7:0] index;
    logic [7:0] ldn;
    logic [7:0] data;
  } dev_req_t;

endpackage

`default_nettype wire

[src/scfg_key_match.sv]
// ----------------------------------------------------------------------------
// scfg_key_match
// Tracks the unlock key sequence on index-port writes while locked and
// pulses unlock when the last key byte arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module scfg_key_match (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       key_we,
  input  wire logic [7:0] key_byte,
  output logic            unlock
);

  localparam int PROG_W = $clog2(scfg_pkg::KEY_LEN);

  logic [PROG_W-1:0] progress_r;
  logic [PROG_W-1:0] progress_nxt;
  logic              match;
  logic              last;

  assign match = (key_byte == scfg_pkg::UNLOCK_KEY[progress_r]);
  assign last  = (progress_r == PROG_W'(scfg_pkg::KEY_LEN - 1));
  assign unlock = key_we && match && last;

  always_comb begin
    progress_nxt = progress_r;
    if (key_we) begin
      if (match) begin
        progress_nxt = last ? '0 : progress_r + 1'b1;
      end else if (key_byte == scfg_pkg::UNLOCK_KEY[0]) begin
        // A mismatching byte that is itself the first key byte restarts at one.
        progress_nxt = PROG_W'(1);
      end else begin
        progress_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      progress_r <= '0;
    end else begin
      progress_r <= progress_nxt;
    end
  end

endmodule

`default_nettype wire

[src/scfg_dev_regs.sv]
// ----------------------------------------------------------------------------
// scfg_dev_regs
// Per-device register file of the serial logical devices: enable, base
// address high and low, and clock configuration.
// ----------------------------------------------------------------------------
`default_nettype none

module scfg_dev_regs (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire scfg_pkg::dev_req_t  req,
  output logic [7:0]               rd_data
);

  localparam int N = scfg_pkg::NUM_SERIAL_DEVICES;

  logic                        enable_r    [N];
  logic [7:0]                  base_high_r [N];
  logic [7:0]                  base_low_r  [N];
  logic [7:0]                  clock_r     [N];
  logic                        hit;
  logic [scfg_pkg::SLOT_W-1:0] slot;

  always_comb begin
    hit  = 1'b0;
    slot = '0;
    for (int i = 0; i < N; i++) begin
      if (!hit && req.ldn == scfg_pkg::SERIAL_LDN[i]) begin
        hit  = 1'b1;
        slot = scfg_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    rd_data = '0;
    if (hit) begin
      case (req.index)
        scfg_pkg::REG_ENABLE:    rd_data = {7'b0, enable_r[slot]};
        scfg_pkg::REG_BASE_HIGH: rd_data = base_high_r[slot];
        scfg_pkg::REG_BASE_LOW:  rd_data = base_low_r[slot];
        scfg_pkg::REG_CLOCK:     rd_data = clock_r[slot];
        default:                 rd_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) begin
        enable_r[i]    <= 1'b0;
        base_high_r[i] <= '0;
        base_low_r[i]  <= '0;
        clock_r[i]     <= '0;
      end
    end else if (req.wr && hit) begin
      case (req.index)
        scfg_pkg::REG_ENABLE:    enable_r[slot]    <= req.data[0];
        scfg_pkg::REG_BASE_HIGH: base_high_r[slot] <= req.data;
        scfg_pkg::REG_BASE_LOW:  base_low_r[slot]  <= req.data;
        scfg_pkg::REG_CLOCK:     clock_r[slot]     <= req.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[src/superio_config_port.sv]
// ----------------------------------------------------------------------------
// superio_config_port
// Chip side of a Super IO index/data configuration port.
// ----------------------------------------------------------------------------
// Each input transaction is one host byte access to the index or data port and
// yields exactly one result transaction. An access is decoded and applied to
// the configuration state in the cycle it is accepted, and its result lands in
// the output register, visible on the next cycle. The block sustains one access
// per cycle: in_ready is high whenever the output register is empty or being
// taken in the same cycle, so with out_ready held high every cycle carries a
// transaction. The chip identity register sits at APB byte address 0.
`default_nettype none

module superio_config_port (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Access channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic        in_port_sel,
  input  wire logic [7:0]  in_write_byte,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_read_byte,
  output logic             out_unlocked,
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  logic [15:0]        chip_id_r;
  logic               active_r;
  logic               active_nxt;
  logic [7:0]         index_r;
  logic [7:0]         index_nxt;
  logic [7:0]         ldn_r;
  logic [7:0]         ldn_nxt;
  logic               out_valid_r;
  logic [7:0]         out_read_byte_r;
  logic               out_unlocked_r;
  logic [7:0]         rd_nxt;
  logic               in_fire;
  logic               is_write;
  logic               is_data;
  logic               key_we;
  logic               unlock;
  logic [7:0]         dev_rd;
  scfg_pkg::dev_req_t dev_req;
  logic               cfg_wr;

  // Configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                  (cfg_paddr[2] == scfg_pkg::CFG_IDX_CHIP_IDENTITY);
  assign cfg_prdata = (cfg_paddr[2] == scfg_pkg::CFG_IDX_CHIP_IDENTITY) ?
                      {16'b0, chip_id_r} : '0;

  // Handshake
  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_write  = in_req_type;
  assign is_data   = in_port_sel;

  assign out_valid     = out_valid_r;
  assign out_read_byte = out_read_byte_r;
  assign out_unlocked  = out_unlocked_r;

  assign key_we = in_fire && !active_r && is_write && !is_data;

  assign dev_req.wr    = in_fire && active_r && is_write && is_data;
  assign dev_req.index = index_r;
  assign dev_req.ldn   = ldn_r;
  assign dev_req.data  = in_write_byte;

  scfg_key_match u_key_match (
    .clk      (clk),
    .rst_n    (rst_n),
    .key_we   (key_we),
    .key_byte (in_write_byte),
    .unlock   (unlock)
  );

  scfg_dev_regs u_dev_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (dev_req),
    .rd_data (dev_rd)
  );

  always_comb begin
    active_nxt = active_r;
    index_nxt  = index_r;
    ldn_nxt    = ldn_r;
    rd_nxt     = '0;
    if (!active_r) begin
      if (unlock) begin
        active_nxt = 1'b1;
      end
      if (!is_write) begin
        rd_nxt = scfg_pkg::LOCKED_READ;
      end
    end else if (is_write) begin
      if (!is_data) begin
        index_nxt = in_write_byte;
      end else if (index_r == scfg_pkg::REG_LOCK) begin
        if (in_write_byte[scfg_pkg::LOCK_BIT]) begin
          active_nxt = 1'b0;
        end
      end else if (index_r == scfg_pkg::REG_LDN) begin
        ldn_nxt = in_write_byte;
      end
    end else if (!is_data) begin
      rd_nxt = index_r;
    end else begin
      case (index_r)
        scfg_pkg::REG_LDN:     rd_nxt = ldn_r;
        scfg_pkg::REG_ID_HIGH: rd_nxt = chip_id_r[15:8];
        scfg_pkg::REG_ID_LOW:  rd_nxt = chip_id_r[7:0];
        default:               rd_nxt = dev_rd;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_id_r   <= scfg_pkg::CHIP_IDENTITY_RESET;
      active_r    <= 1'b0;
      index_r     <= '0;
      ldn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        chip_id_r <= cfg_pwdata[15:0];
      end
      if (in_fire) begin
        active_r    <= active_nxt;
        index_r     <= index_nxt;
        ldn_r       <= ldn_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_read_byte_r <= rd_nxt;
      out_unlocked_r  <= active_nxt;
    end
  end

endmodule

`default_nettype wire

[test/superio_config_port_tb.sv]
// ----------------------------------------------------------------------------
// superio_config_port_tb
// Self-checking bench for the Super IO index/data configuration port. Host
// byte accesses are queued by a stimulus process, presented by a clocked
// driver and predicted on acceptance. A clocked monitor compares every result
// transaction with the oldest prediction. The run covers the unlock key with
// and without mismatches, register access to every serial logical device,
// and relocking. It steps through several chip identity values and through
// phases with random gaps on the input side, stalls on the output side, or both.
// ----------------------------------------------------------------------------
`default_nettype none

module superio_config_port_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic {ACC_READ = 1'b0, ACC_WRITE = 1'b1} acc_kind_t;
  typedef enum logic {PORT_INDEX = 1'b0, PORT_DATA = 1'b1} port_t;

  typedef struct packed {
    acc_kind_t  req_type;
    port_t      port_sel;
    logic [7:0] wbyte;
  } host_access_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       unlocked;
  } port_result_t;

  localparam int RANDOM_PER_PHASE = 250;
  localparam logic [2:0] ADDR_CHIP_IDENTITY = {scfg_pkg::CFG_IDX_CHIP_IDENTITY, 2'b00};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic        in_port_sel = 1'b0;
  logic [7:0]  in_write_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_read_byte;
  logic        out_unlocked;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = 3'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  superio_config_port dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_port_sel   (in_port_sel),
    .in_write_byte (in_write_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_byte (out_read_byte),
    .out_unlocked  (out_unlocked),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow of the chip's configuration state.
  logic [15:0] chip_id = scfg_pkg::CHIP_IDENTITY_RESET;
  logic [2:0]  key_matched = 3'd0;
  logic        cfg_mode = 1'b0;
  logic [7:0]  sel_index = 8'h00;
  logic [7:0]  sel_device = 8'h00;
  logic        dev_en [6] = '{default: 1'b0};
  logic [7:0]  dev_base_hi [6] = '{default: 8'h00};
  logic [7:0]  dev_base_lo [6] = '{default: 8'h00};
  logic [7:0]  dev_clk_cfg [6] = '{default: 8'h00};

  host_access_t pending_access_q [$];
  port_result_t predicted_result_q [$];
  host_access_t cur_access;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int accesses_queued = 0;
  int results_seen = 0;
  int errors = 0;

  // Applies one host access to the shadow state and returns what the chip
  // should answer.
  function automatic port_result_t predict_access(host_access_t acc);
    port_result_t res;
    int slot;
    int i;
    logic [2:0] step;
    slot = -1;
    for (i = 0; i < scfg_pkg::NUM_SERIAL_DEVICES; i++) begin
      if (slot < 0 && scfg_pkg::SERIAL_LDN[i] == sel_device) slot = i;
    end
    res.read_byte = 8'h00;
    if (!cfg_mode) begin
      if (acc.req_type == ACC_WRITE) begin
        if (acc.port_sel == PORT_INDEX) begin
          step = (key_matched < scfg_pkg::KEY_LEN) ? key_matched : 3'd0;
          if (acc.wbyte == scfg_pkg::UNLOCK_KEY[step]) begin
            if (step == scfg_pkg::KEY_LEN - 1) begin
              cfg_mode = 1'b1;
              key_matched = 3'd0;
            end else begin
              key_matched = step + 3'd1;
            end
          end else begin
            // A wrong byte restarts the match, but may itself open a new one.
            key_matched = (acc.wbyte == scfg_pkg::UNLOCK_KEY[0]) ? 3'd1 : 3'd0;
          end
        end
      end else begin
        res.read_byte = scfg_pkg::LOCKED_READ;
      end
    end else if (acc.req_type == ACC_WRITE) begin
      if (acc.port_sel == PORT_INDEX) begin
        sel_index = acc.wbyte;
      end else if (sel_index == scfg_pkg::REG_LOCK) begin
        if (acc.wbyte[scfg_pkg::LOCK_BIT]) begin
          cfg_mode = 1'b0;
          key_matched = 3'd0;
        end
      end else if (sel_index == scfg_pkg::REG_LDN) begin
        sel_device = acc.wbyte;
      end else if (slot >= 0) begin
        case (sel_index)
          scfg_pkg::REG_ENABLE:    dev_en[slot] = acc.wbyte[0];
          scfg_pkg::REG_BASE_HIGH: dev_base_hi[slot] = acc.wbyte;
          scfg_pkg::REG_BASE_LOW:  dev_base_lo[slot] = acc.wbyte;
          scfg_pkg::REG_CLOCK:     dev_clk_cfg[slot] = acc.wbyte;
          default: ;
        endcase
      end
    end else if (acc.port_sel == PORT_INDEX) begin
      res.read_byte = sel_index;
    end else begin
      case (sel_index)
        scfg_pkg::REG_LDN:     res.read_byte = sel_device;
        scfg_pkg::REG_ID_HIGH: res.read_byte = chip_id[15:8];
        scfg_pkg::REG_ID_LOW:  res.read_byte = chip_id[7:0];
        default: begin
          if (slot >= 0) begin
            case (sel_index)
              scfg_pkg::REG_ENABLE:    res.read_byte = {7'd0, dev_en[slot]};
              scfg_pkg::REG_BASE_HIGH: res.read_byte = dev_base_hi[slot];
              scfg_pkg::REG_BASE_LOW:  res.read_byte = dev_base_lo[slot];
              scfg_pkg::REG_CLOCK:     res.read_byte = dev_clk_cfg[slot];
              default: ;
            endcase
          end
        end
      endcase
    end
    res.unlocked = cfg_mode;
    return res;
  endfunction

  // Driver: predicts each transaction as it is accepted and presents the next.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predicted_result_q.push_back(predict_access(cur_access));
      if (!in_valid || in_ready) begin
        if (pending_access_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_access = pending_access_q.pop_front();
          in_valid <= 1'b1;
          in_req_type <= cur_access.req_type;
          in_port_sel <= cur_access.port_sel;
          in_write_byte <= cur_access.wbyte;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every result transaction against the oldest prediction.
  always @(posedge clk) begin
    port_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (predicted_result_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result read_byte=%02h unlocked=%0b", $time,
                   out_read_byte, out_unlocked);
        end else begin
          want = predicted_result_q.pop_front();
          if (out_read_byte !== want.read_byte) begin
            errors++;
            $display("%0t: read_byte expected %02h actual %02h", $time,
                     want.read_byte, out_read_byte);
          end
          if (out_unlocked !== want.unlocked) begin
            errors++;
            $display("%0t: unlocked expected %0b actual %0b", $time,
                     want.unlocked, out_unlocked);
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic queue_access(acc_kind_t kind, port_t port, logic [7:0] value);
    host_access_t acc;
    acc.req_type = kind;
    acc.port_sel = port;
    acc.wbyte = value;
    pending_access_q.push_back(acc);
    accesses_queued++;
  endtask

  task automatic queue_key();
    int i;
    for (i = 0; i < scfg_pkg::KEY_LEN; i++) begin
      queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::UNLOCK_KEY[i]);
    end
  endtask

  task automatic queue_noise(int count);
    int i;
    for (i = 0; i < count; i++) begin
      queue_access(acc_kind_t'($urandom_range(0, 1)), port_t'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)));
    end
  endtask

  // Mostly complete unlock sessions with random register traffic, plus broken
  // key sequences and raw noise.
  task automatic queue_random_phase(int count);
    int start;
    int ops;
    int i;
    int k;
    logic [7:0] idx;
    logic [7:0] value;
    start = accesses_queued;
    while (accesses_queued - start < count) begin
      k = $urandom_range(0, 9);
      if (k < 7) begin
        if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 2));
        queue_key();
        ops = $urandom_range(1, 12);
        for (i = 0; i < ops; i++) begin
          case ($urandom_range(0, 9))
            0:       idx = scfg_pkg::REG_LDN;
            1:       idx = scfg_pkg::REG_ID_HIGH;
            2:       idx = scfg_pkg::REG_ID_LOW;
            3, 4:    idx = scfg_pkg::REG_ENABLE;
            5:       idx = scfg_pkg::REG_BASE_HIGH;
            6:       idx = scfg_pkg::REG_BASE_LOW;
            7:       idx = scfg_pkg::REG_CLOCK;
            8:       idx = 8'($urandom_range(0, 255));
            default: idx = ($urandom_range(0, 3) == 0) ? scfg_pkg::REG_LOCK
                                                        : scfg_pkg::REG_LDN;
          endcase
          queue_access(ACC_WRITE, PORT_INDEX, idx);
          case ($urandom_range(0, 3))
            0: queue_access(ACC_READ, PORT_DATA, 8'($urandom_range(0, 255)));
            1: queue_access(ACC_READ, PORT_INDEX, 8'($urandom_range(0, 255)));
            default: begin
              if (idx == scfg_pkg::REG_LDN && $urandom_range(0, 3) != 0)
                value = scfg_pkg::SERIAL_LDN[$urandom_range(0, 5)];
              else
                value = 8'($urandom_range(0, 255));
              queue_access(ACC_WRITE, PORT_DATA, value);
              if ($urandom_range(0, 1) == 0) queue_access(ACC_READ, PORT_DATA, 8'h00);
            end
          endcase
        end
        if ($urandom_range(0, 1) == 0) begin
          queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::REG_LOCK);
          queue_access(ACC_WRITE, PORT_DATA, 8'($urandom_range(0, 255)) | 8'h02);
        end
      end else if (k < 9) begin
        // Partial key followed by a wrong or restarting byte.
        ops = $urandom_range(0, scfg_pkg::KEY_LEN - 1);
        for (i = 0; i < ops; i++) begin
          queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::UNLOCK_KEY[i]);
        end
        case ($urandom_range(0, 2))
          0: queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::UNLOCK_KEY[0]);
          1: queue_access(ACC_WRITE, PORT_INDEX, 8'($urandom_range(0, 255)));
          default: queue_noise(1);
        endcase
      end else begin
        queue_noise($urandom_range(1, 3));
      end
    end
  endtask

  task automatic wait_drained();
    while (pending_access_q.size() != 0 || results_seen < accesses_queued) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_chip_identity(logic [15:0] id);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= ADDR_CHIP_IDENTITY;
    cfg_pwdata <= {16'h0000, id};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    chip_id = id;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Locked reads and a locked data write, then a key with a restart in it.
    queue_access(ACC_READ, PORT_INDEX, 8'h00);
    queue_access(ACC_READ, PORT_DATA, 8'hFF);
    queue_access(ACC_WRITE, PORT_DATA, 8'hFF);
    queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::UNLOCK_KEY[0]);
    queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::UNLOCK_KEY[1]);
    queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::UNLOCK_KEY[0]);
    queue_key();
    queue_access(ACC_READ, PORT_INDEX, 8'h00);
    queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::REG_ID_HIGH);
    queue_access(ACC_READ, PORT_DATA, 8'h00);
    queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::REG_ID_LOW);
    queue_access(ACC_READ, PORT_DATA, 8'h00);
    queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::REG_LDN);
    queue_access(ACC_WRITE, PORT_DATA, scfg_pkg::SERIAL_LDN[5]);
    queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::REG_ENABLE);
    queue_access(ACC_WRITE, PORT_DATA, 8'hFF);
    queue_access(ACC_READ, PORT_DATA, 8'h00);
    // Lock register write without the lock bit, a read of it, then a real lock.
    queue_access(ACC_WRITE, PORT_INDEX, scfg_pkg::REG_LOCK);
    queue_access(ACC_WRITE, PORT_DATA, 8'hFD);
    queue_access(ACC_READ, PORT_DATA, 8'h00);
    queue_access(ACC_WRITE, PORT_DATA, 8'h02);
    queue_access(ACC_READ, PORT_DATA, 8'h00);

    queue_random_phase(RANDOM_PER_PHASE);
    wait_drained();

    write_chip_identity(16'hFFFF);
    send_idle_pct = 81;
    queue_random_phase(RANDOM_PER_PHASE);
    wait_drained();

    write_chip_identity(16'h0000);
    send_idle_pct = 0;
    recv_stall_pct = 81;
    queue_random_phase(RANDOM_PER_PHASE);
    wait_drained();

    write_chip_identity(16'($urandom_range(1, 16'hFFFE)));
    send_idle_pct = 30;
    recv_stall_pct = 30;
    queue_random_phase(RANDOM_PER_PHASE);
    wait_drained();

    repeat (4) @(posedge clk);
    if (errors == 0 && predicted_result_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (predicted_result_q.size() != 0)
        $display("%0t: %0d predicted results never arrived", $time, predicted_result_q.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
src/scfg_pkg.sv
src/scfg_key_match.sv
src/scfg_dev_regs.sv
src/superio_config_port.sv
test/superio_config_port_tb.sv
